// ===== hw/rtl/tlik_pkg.sv =====
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared widths, stage counts, cell link types and constant tables for the
// two-link arm inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package tlik_pkg;

    // cordic sizing
    localparam int CORDIC_STAGES = 16;
    localparam int POSITION_BITS = 16;
    localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
    localparam int CORD_IN_W     = 26;
    localparam int CORD_W        = POSITION_BITS + 28;
    localparam int ACC_W         = 35;
    localparam int ANG_W         = 20;
    localparam int STAGE_W       = 5;

    // square root sizing
    localparam int RAD_W       = 48;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 3;
    localparam int SQRT_STAGES = RAD_W / 2;

    // divider sizing
    localparam int DIV_W      = 58;
    localparam int QUO_W      = 18;
    localparam int DIV_STAGES = QUO_W;

    localparam logic signed [ACC_W-1:0] PI_Q30 = 35'sd3373259426;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ACC_W-1:0]  ang;
        logic                     zero;
    } cordic_link_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_link_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dsh;
        logic [QUO_W-1:0] quo;
    } div_link_t;

    // arctan(2^-i) in q30, rounded to nearest
    function automatic logic [29:0] atan_q30(input logic [STAGE_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/tlik_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// tlik_cordic_cell
// One vectoring-mode cordic micro-rotation, registered.
// ----------------------------------------------------------------------------
module tlik_cordic_cell (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic [tlik_pkg::STAGE_W-1:0]         stage,
    input  tlik_pkg::cordic_link_t               link_in,
    output tlik_pkg::cordic_link_t               link_out
);
    logic signed [tlik_pkg::CORD_W-1:0] xv, yv, xsh, ysh;
    logic signed [tlik_pkg::ACC_W-1:0]  av, step;
    tlik_pkg::cordic_link_t             link_reg;

    assign xv   = link_in.x;
    assign yv   = link_in.y;
    assign av   = link_in.ang;
    assign xsh  = xv >>> stage;
    assign ysh  = yv >>> stage;
    assign step = tlik_pkg::ACC_W'(tlik_pkg::atan_q30(stage));

    always_ff @(posedge aclk) begin
        if (en) begin
            link_reg.zero <= link_in.zero;
            // rotate toward the x axis
            if (!yv[tlik_pkg::CORD_W-1] && (yv != '0)) begin
                link_reg.x   <= xv + ysh;
                link_reg.y   <= yv - xsh;
                link_reg.ang <= av + step;
            end else begin
                link_reg.x   <= xv - ysh;
                link_reg.y   <= yv + xsh;
                link_reg.ang <= av - step;
            end
        end
    end

    assign link_out = link_reg;
endmodule

// ===== hw/rtl/tlik_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tlik_sqrt_cell
// One digit step of a floor square root, two radicand bits per cell.
// ----------------------------------------------------------------------------
module tlik_sqrt_cell (
    input  logic                  aclk,
    input  logic                  en,
    input  tlik_pkg::sqrt_link_t  link_in,
    output tlik_pkg::sqrt_link_t  link_out
);
    localparam int RW = tlik_pkg::REM_W;
    localparam int QW = tlik_pkg::ROOT_W;
    localparam int DW = tlik_pkg::RAD_W;

    logic [RW-1:0]        rem_sh, trial;
    logic                 take;
    tlik_pkg::sqrt_link_t link_reg;

    assign rem_sh = {link_in.rem[RW-3:0], link_in.rad[DW-1 -: 2]};
    assign trial  = {1'b0, link_in.root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (en) begin
            link_reg.rad <= {link_in.rad[DW-3:0], 2'b00};
            if (take) begin
                link_reg.rem  <= rem_sh - trial;
                link_reg.root <= {link_in.root[QW-2:0], 1'b1};
            end else begin
                link_reg.rem  <= rem_sh;
                link_reg.root <= {link_in.root[QW-2:0], 1'b0};
            end
        end
    end

    assign link_out = link_reg;
endmodule

// ===== hw/rtl/tlik_div_cell.sv =====
// ----------------------------------------------------------------------------
// tlik_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module tlik_div_cell (
    input  logic                 aclk,
    input  logic                 en,
    input  tlik_pkg::div_link_t  link_in,
    output tlik_pkg::div_link_t  link_out
);
    localparam int QW = tlik_pkg::QUO_W;

    logic                take;
    tlik_pkg::div_link_t link_reg;

    assign take = (link_in.rem >= link_in.dsh);

    always_ff @(posedge aclk) begin
        if (en) begin
            link_reg.dsh <= link_in.dsh >> 1;
            if (take) begin
                link_reg.rem <= link_in.rem - link_in.dsh;
                link_reg.quo <= {link_in.quo[QW-2:0], 1'b1};
            end else begin
                link_reg.rem <= link_in.rem;
                link_reg.quo <= {link_in.quo[QW-2:0], 1'b0};
            end
        end
    end

    assign link_out = link_reg;
endmodule

// ===== hw/rtl/tlik_cordic.sv =====
// ----------------------------------------------------------------------------
// tlik_cordic
// Pipelined atan2(y, x): half-plane fold, chain of cordic cells, q16 rounding.
// ----------------------------------------------------------------------------
module tlik_cordic (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic signed [tlik_pkg::CORD_IN_W-1:0] y_in,
    input  logic signed [tlik_pkg::CORD_IN_W-1:0] x_in,
    output logic signed [tlik_pkg::ANG_W-1:0]     ang_out
);
    localparam int IW = tlik_pkg::CORD_IN_W;
    localparam int CW = tlik_pkg::CORD_W;
    localparam int AW = tlik_pkg::ACC_W;
    localparam int NS = tlik_pkg::CORDIC_STAGES;

    logic signed [CW-1:0]   xs, ys;
    logic signed [AW-1:0]   ang_rnd;
    logic signed [tlik_pkg::ANG_W-1:0] ang_reg;
    tlik_pkg::cordic_link_t link [NS+1];
    tlik_pkg::cordic_link_t prep_reg;

    assign xs = {{(CW-IW){x_in[IW-1]}}, x_in} <<< tlik_pkg::POSITION_BITS;
    assign ys = {{(CW-IW){y_in[IW-1]}}, y_in} <<< tlik_pkg::POSITION_BITS;

    // left half plane folds onto the right with a start angle of +-pi
    always_ff @(posedge aclk) begin
        if (en) begin
            prep_reg.zero <= (x_in == '0) && (y_in == '0);
            if (x_in[IW-1]) begin
                prep_reg.x   <= -xs;
                prep_reg.y   <= -ys;
                prep_reg.ang <= y_in[IW-1] ? -tlik_pkg::PI_Q30 : tlik_pkg::PI_Q30;
            end else begin
                prep_reg.x   <= xs;
                prep_reg.y   <= ys;
                prep_reg.ang <= '0;
            end
        end
    end

    assign link[0] = prep_reg;

    for (genvar i = 0; i < NS; i++) begin : g_cell
        tlik_cordic_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .stage    (tlik_pkg::STAGE_W'(i)),
            .link_in  (link[i]),
            .link_out (link[i+1])
        );
    end

    assign ang_rnd = (link[NS].ang + AW'(8192)) >>> 14;

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= link[NS].zero ? '0 : ang_rnd[tlik_pkg::ANG_W-1:0];
        end
    end

    assign ang_out = ang_reg;
endmodule

// ===== hw/rtl/two_link_arm_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics
// Target point to five servo tick positions for a two-link arm, fully
// pipelined through chains of square root, divider and cordic cells.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata: target_x, target_y, target_z
//  m_       out  m_tvalid/m_tready  m_tdata: five 12 bit ticks, m_tuser: out_of_reach
//  apb      in   psel/penable       upper_link_length @0x0, lower_link_length @0x4
//
//  one beat is accepted per cycle while the skid entry is empty; each result
//  passes through the serial chain root -> divide -> root -> cordic
//  every stage moves together; while a result waits the pipe keeps moving
//  until the next result lands in the skid entry, then all stages and s_tready hold
//  aresetn clears the valid bits, output and skid flags and reloads the link lengths
//
module two_link_arm_inverse_kinematics (
    input  logic        aclk,
    input  logic        aresetn,
    // target beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // target_x, target_y, target_z
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // shoulder pitch, shoulder roll, elbow,
                                    // wrist pitch, wrist roll ticks, zero pad
    output logic        m_tuser,    // out_of_reach
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CL      = tlik_pkg::CORDIC_LAT;
    localparam int SQ      = tlik_pkg::SQRT_STAGES;
    localparam int DV      = tlik_pkg::DIV_STAGES;
    localparam int IW      = tlik_pkg::CORD_IN_W;
    localparam int GW      = tlik_pkg::ANG_W;
    localparam int QW      = tlik_pkg::QUO_W;
    localparam int DW      = tlik_pkg::DIV_W;
    // stage where each value becomes valid, counted from the input register
    localparam int T_ROOT  = 2 + SQ;
    localparam int T_C     = T_ROOT + 3 + DV;
    localparam int T_S     = T_C + 1 + SQ;
    localparam int T_BETA  = T_S + CL;
    localparam int T_ALPHA = T_ROOT + CL;
    localparam int T_TICK  = T_BETA + 3;
    localparam int D_ALPHA = T_BETA - T_ALPHA;
    localparam int D_ROLL  = T_BETA - CL;
    localparam int D_FLAG  = T_TICK - T_C - 1;

    localparam logic [1:0]  REG_UPPER = 2'd0;
    localparam logic [13:0] UPPER_RST = 14'd2550;
    localparam logic [13:0] LOWER_RST = 14'd2250;
    localparam logic signed [21:0] HALF_PI_Q16 = 22'sd102944;
    localparam logic signed [49:0] GAIN_LIFT     = 50'sd74472489;
    localparam logic signed [49:0] GAIN_SH_ROLL  = 50'sd42889380;
    localparam logic signed [49:0] GAIN_JOINT    = 50'sd42722263;
    localparam logic signed [49:0] OFS_LIFT      = 50'sd3000 <<< 32;
    localparam logic signed [49:0] OFS_SH_ROLL   = 50'sd2052 <<< 32;
    localparam logic signed [49:0] OFS_JOINT     = 50'sd2048 <<< 32;
    localparam logic signed [49:0] OFS_WR_PITCH  = 50'sd1948 <<< 32;
    localparam logic signed [QW-1:0] C_ONE = 18'sd65536;

    // saturate a q32 tick value to 0..4095
    function automatic logic [11:0] sat_ticks(input logic signed [49:0] v);
        logic [11:0] t;
        if (v[49])            t = 12'd0;
        else if (|v[48:44])   t = 12'd4095;
        else                  t = v[43:32];
        return t;
    endfunction

    // ---------------- register port ----------------
    logic [13:0] upper_len_reg, lower_len_reg;
    logic [27:0] upper_sq_reg, lower_sq_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? {18'd0, lower_len_reg} : {18'd0, upper_len_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_len_reg <= UPPER_RST;
            lower_len_reg <= LOWER_RST;
        end else if (cfg_wr) begin
            if ({1'b0, paddr[2]} == REG_UPPER) begin
                upper_len_reg <= pwdata[13:0];
            end else begin
                lower_len_reg <= pwdata[13:0];
            end
        end
    end

    // link squares follow the registers in the next cycle
    always_ff @(posedge aclk) begin
        upper_sq_reg <= 28'(upper_len_reg) * 28'(upper_len_reg);
        lower_sq_reg <= 28'(lower_len_reg) * 28'(lower_len_reg);
    end

    // ---------------- flow control ----------------
    logic adv;
    logic skid_valid_reg, m_valid_reg;
    logic [59:0] skid_data_reg, m_data_reg;
    logic        skid_user_reg, m_user_reg;
    logic [T_TICK:0] vld_reg;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv && aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[T_TICK-1:0], s_tvalid};
        end
    end

    // ---------------- input and squares ----------------
    logic signed [15:0] x_in_reg, y_in_reg, z_in_reg;
    logic [31:0] xsq_reg, ysq_reg, zsq_reg, r2_reg, d2_reg;
    logic signed [31:0] xsq_full, ysq_full, zsq_full;

    assign xsq_full = x_in_reg * x_in_reg;
    assign ysq_full = y_in_reg * y_in_reg;
    assign zsq_full = z_in_reg * z_in_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_in_reg <= s_tdata[15:0];
            y_in_reg <= s_tdata[31:16];
            z_in_reg <= s_tdata[47:32];
            xsq_reg  <= xsq_full;
            ysq_reg  <= ysq_full;
            zsq_reg  <= zsq_full;
            r2_reg   <= ysq_reg + zsq_reg;
            d2_reg   <= xsq_reg + ysq_reg + zsq_reg;
        end
    end

    // shoulder roll runs straight from the input register
    logic signed [GW-1:0] roll_ang;

    tlik_cordic u_roll (
        .aclk    (aclk),
        .en      (adv),
        .y_in    (IW'(y_in_reg)),
        .x_in    (IW'(z_in_reg)),
        .ang_out (roll_ang)
    );

    // ---------------- reach and distance roots ----------------
    tlik_pkg::sqrt_link_t r_link [SQ+1];
    tlik_pkg::sqrt_link_t d_link [SQ+1];

    assign r_link[0] = '{rad: {r2_reg, 16'd0}, rem: '0, root: '0};
    assign d_link[0] = '{rad: {d2_reg, 16'd0}, rem: '0, root: '0};

    for (genvar i = 0; i < SQ; i++) begin : g_rd_root
        tlik_sqrt_cell u_r (.aclk(aclk), .en(adv), .link_in(r_link[i]), .link_out(r_link[i+1]));
        tlik_sqrt_cell u_d (.aclk(aclk), .en(adv), .link_in(d_link[i]), .link_out(d_link[i+1]));
    end

    logic signed [15:0] x_dly_reg  [T_ROOT];
    logic [31:0]        d2_dly_reg [SQ];

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_dly_reg[0]  <= x_in_reg;
            d2_dly_reg[0] <= d2_reg;
            for (int i = 1; i < T_ROOT; i++) x_dly_reg[i] <= x_dly_reg[i-1];
            for (int i = 1; i < SQ; i++) d2_dly_reg[i] <= d2_dly_reg[i-1];
        end
    end

    // elevation of the target seen from the shoulder
    logic signed [GW-1:0] alpha_ang;
    logic signed [IW-1:0] alpha_y, alpha_x;

    assign alpha_y = IW'($signed({x_dly_reg[T_ROOT-1], 8'd0}));
    assign alpha_x = IW'({1'b0, r_link[SQ].root});

    tlik_cordic u_alpha (
        .aclk    (aclk),
        .en      (adv),
        .y_in    (alpha_y),
        .x_in    (alpha_x),
        .ang_out (alpha_ang)
    );

    // ---------------- law of cosines quotients ----------------
    logic signed [33:0] num1_reg, num2_reg;
    logic [38:0]        den1_reg, den2_reg, den1_abs_reg, den2_abs_reg;
    logic [37:0]        den1_prod, den2_prod;
    logic [33:0]        mag1, mag2;
    logic [DW-1:0]      n1_reg, n2_reg;
    logic               neg1_reg, neg2_reg;
    logic [2:0]         ctl1_next, ctl2_next;   // overflow, negative, zero divisor

    assign den1_prod = 38'(upper_len_reg) * 38'(d_link[SQ].root);
    assign den2_prod = 38'(lower_len_reg) * 38'(d_link[SQ].root);

    always_ff @(posedge aclk) begin
        if (adv) begin
            num1_reg <= 34'(upper_sq_reg) + 34'(d2_dly_reg[SQ-1]) - 34'(lower_sq_reg);
            num2_reg <= 34'(lower_sq_reg) + 34'(d2_dly_reg[SQ-1]) - 34'(upper_sq_reg);
            den1_reg <= {den1_prod, 1'b0};
            den2_reg <= {den2_prod, 1'b0};
        end
    end

    assign mag1 = num1_reg[33] ? 34'(-num1_reg) : 34'(num1_reg);
    assign mag2 = num2_reg[33] ? 34'(-num2_reg) : 34'(num2_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            n1_reg       <= {mag1, 24'd0};
            n2_reg       <= {mag2, 24'd0};
            neg1_reg     <= num1_reg[33];
            neg2_reg     <= num2_reg[33];
            den1_abs_reg <= den1_reg;
            den2_abs_reg <= den2_reg;
        end
    end

    assign ctl1_next = {n1_reg >= {1'b0, den1_abs_reg, 18'd0}, neg1_reg, den1_abs_reg == '0};
    assign ctl2_next = {n2_reg >= {1'b0, den2_abs_reg, 18'd0}, neg2_reg, den2_abs_reg == '0};

    tlik_pkg::div_link_t q1_link [DV+1];
    tlik_pkg::div_link_t q2_link [DV+1];

    assign q1_link[0] = '{rem: n1_reg, dsh: {2'b00, den1_abs_reg, 17'd0}, quo: '0};
    assign q2_link[0] = '{rem: n2_reg, dsh: {2'b00, den2_abs_reg, 17'd0}, quo: '0};

    for (genvar i = 0; i < DV; i++) begin : g_div
        tlik_div_cell u_q1 (.aclk(aclk), .en(adv), .link_in(q1_link[i]), .link_out(q1_link[i+1]));
        tlik_div_cell u_q2 (.aclk(aclk), .en(adv), .link_in(q2_link[i]), .link_out(q2_link[i+1]));
    end

    logic [2:0] ctl1_dly_reg [DV];
    logic [2:0] ctl2_dly_reg [DV];

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl1_dly_reg[0] <= ctl1_next;
            ctl2_dly_reg[0] <= ctl2_next;
            for (int i = 1; i < DV; i++) begin
                ctl1_dly_reg[i] <= ctl1_dly_reg[i-1];
                ctl2_dly_reg[i] <= ctl2_dly_reg[i-1];
            end
        end
    end

    // clamp to [-1, 1]; zero divisor reads as +1
    logic signed [QW-1:0] c1_next, c2_next, c1_reg, c2_reg, c1w_reg, c2w_reg;
    logic                 fl1_next, fl2_next, flag_reg;
    logic [2:0]           k1, k2;
    logic [QW-1:0]        q1, q2;

    assign k1 = ctl1_dly_reg[DV-1];
    assign k2 = ctl2_dly_reg[DV-1];
    assign q1 = q1_link[DV].quo;
    assign q2 = q2_link[DV].quo;

    always_comb begin
        if (k1[0]) begin
            c1_next = C_ONE;
            fl1_next = 1'b1;
        end else if (k1[2] || (q1 > QW'(65536))) begin
            c1_next = k1[1] ? -C_ONE : C_ONE;
            fl1_next = 1'b1;
        end else begin
            c1_next = k1[1] ? -$signed(q1) : $signed(q1);
            fl1_next = 1'b0;
        end
        if (k2[0]) begin
            c2_next = C_ONE;
            fl2_next = 1'b1;
        end else if (k2[2] || (q2 > QW'(65536))) begin
            c2_next = k2[1] ? -C_ONE : C_ONE;
            fl2_next = 1'b1;
        end else begin
            c2_next = k2[1] ? -$signed(q2) : $signed(q2);
            fl2_next = 1'b0;
        end
    end

    logic [32:0]        csq1_reg, csq2_reg;
    logic signed [35:0] csq1_full, csq2_full;

    assign csq1_full = c1_reg * c1_reg;
    assign csq2_full = c2_reg * c2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_reg   <= c1_next;
            c2_reg   <= c2_next;
            flag_reg <= fl1_next || fl2_next;
            csq1_reg <= csq1_full[32:0];
            csq2_reg <= csq2_full[32:0];
            c1w_reg  <= c1_reg;
            c2w_reg  <= c2_reg;
        end
    end

    // ---------------- sine roots ----------------
    tlik_pkg::sqrt_link_t s1_link [SQ+1];
    tlik_pkg::sqrt_link_t s2_link [SQ+1];

    assign s1_link[0] = '{rad: tlik_pkg::RAD_W'(33'h1_0000_0000 - csq1_reg), rem: '0, root: '0};
    assign s2_link[0] = '{rad: tlik_pkg::RAD_W'(33'h1_0000_0000 - csq2_reg), rem: '0, root: '0};

    for (genvar i = 0; i < SQ; i++) begin : g_s_root
        tlik_sqrt_cell u_s1 (.aclk(aclk), .en(adv), .link_in(s1_link[i]), .link_out(s1_link[i+1]));
        tlik_sqrt_cell u_s2 (.aclk(aclk), .en(adv), .link_in(s2_link[i]), .link_out(s2_link[i+1]));
    end

    logic signed [QW-1:0] c1_dly_reg [SQ];
    logic signed [QW-1:0] c2_dly_reg [SQ];

    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_dly_reg[0] <= c1w_reg;
            c2_dly_reg[0] <= c2w_reg;
            for (int i = 1; i < SQ; i++) begin
                c1_dly_reg[i] <= c1_dly_reg[i-1];
                c2_dly_reg[i] <= c2_dly_reg[i-1];
            end
        end
    end

    // acos as atan2(sin, cos)
    logic signed [GW-1:0] beta1_ang, beta2_ang;

    tlik_cordic u_beta1 (
        .aclk    (aclk),
        .en      (adv),
        .y_in    (IW'({1'b0, s1_link[SQ].root})),
        .x_in    (IW'(c1_dly_reg[SQ-1])),
        .ang_out (beta1_ang)
    );

    tlik_cordic u_beta2 (
        .aclk    (aclk),
        .en      (adv),
        .y_in    (IW'({1'b0, s2_link[SQ].root})),
        .x_in    (IW'(c2_dly_reg[SQ-1])),
        .ang_out (beta2_ang)
    );

    // ---------------- alignment lines ----------------
    logic signed [GW-1:0] alpha_dly_reg [D_ALPHA];
    logic signed [GW-1:0] roll_dly_reg  [D_ROLL];
    logic                 flag_dly_reg  [D_FLAG];

    always_ff @(posedge aclk) begin
        if (adv) begin
            alpha_dly_reg[0] <= alpha_ang;
            roll_dly_reg[0]  <= roll_ang;
            flag_dly_reg[0]  <= flag_reg;
            for (int i = 1; i < D_ALPHA; i++) alpha_dly_reg[i] <= alpha_dly_reg[i-1];
            for (int i = 1; i < D_ROLL; i++) roll_dly_reg[i] <= roll_dly_reg[i-1];
            for (int i = 1; i < D_FLAG; i++) flag_dly_reg[i] <= flag_dly_reg[i-1];
        end
    end

    // ---------------- joint angles and ticks ----------------
    logic signed [21:0] alpha_x22, roll_x22, b1_x22, b2_x22;
    logic signed [21:0] sp_reg, sr_reg, el_reg, wp_reg, wr_reg;
    logic signed [49:0] sp_prod_reg, sr_prod_reg, el_prod_reg, wp_prod_reg, wr_prod_reg;
    logic [59:0]        tick_data;

    assign alpha_x22 = 22'(alpha_dly_reg[D_ALPHA-1]);
    assign roll_x22  = 22'(roll_dly_reg[D_ROLL-1]);
    assign b1_x22    = 22'(beta1_ang);
    assign b2_x22    = 22'(beta2_ang);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sp_reg <= alpha_x22 - b1_x22;
            sr_reg <= roll_x22;
            el_reg <= b1_x22 + b2_x22;
            wp_reg <= HALF_PI_Q16 - alpha_x22 - b2_x22;
            wr_reg <= -roll_x22;
            sp_prod_reg <= GAIN_LIFT     * 50'(sp_reg);
            sr_prod_reg <= GAIN_SH_ROLL  * 50'(sr_reg);
            el_prod_reg <= GAIN_JOINT    * 50'(el_reg);
            wp_prod_reg <= GAIN_JOINT    * 50'(wp_reg);
            wr_prod_reg <= GAIN_JOINT    * 50'(wr_reg);
        end
    end

    assign tick_data = {sat_ticks(OFS_JOINT    - wr_prod_reg),
                        sat_ticks(OFS_WR_PITCH - wp_prod_reg),
                        sat_ticks(OFS_JOINT    - el_prod_reg),
                        sat_ticks(OFS_SH_ROLL  - sr_prod_reg),
                        sat_ticks(OFS_LIFT     - sp_prod_reg)};

    logic [59:0] pipe_data_reg;
    logic        pipe_user_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pipe_data_reg <= tick_data;
            pipe_user_reg <= flag_dly_reg[D_FLAG-1];
        end
    end

    // ---------------- output register and skid ----------------
    logic pipe_valid;

    assign pipe_valid = vld_reg[T_TICK];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (pipe_valid) begin
            if (m_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                m_data_reg <= skid_data_reg;
                m_user_reg <= skid_user_reg;
            end
        end else if (pipe_valid) begin
            if (m_valid_reg && !m_tready) begin
                skid_data_reg <= pipe_data_reg;
                skid_user_reg <= pipe_user_reg;
            end else begin
                m_data_reg <= pipe_data_reg;
                m_user_reg <= pipe_user_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_data_reg};
    assign m_tuser  = m_user_reg;
endmodule

// ===== dv/two_link_arm_inverse_kinematics_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics_tb
// Drives target points through the inverse kinematics pipeline under several
// link length settings and handshake pressure, predicts the five servo tick
// positions and the out of reach flag, and compares every result beat.
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics_tb;

    // register indexes
    localparam int REG_UPPER = 0;
    localparam int REG_LOWER = 1;

    localparam int PIPE_LAT   = 95;
    localparam int STALL_LIMIT = 20000;
    localparam int N_RANDOM   = 1520;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q16 = 64'sd102944;
    localparam longint ONE_Q16     = 64'sd65536;
    localparam longint GAIN_LIFT     = 64'sd74472489;
    localparam longint GAIN_SH_ROLL  = 64'sd42889380;
    localparam longint GAIN_JOINT    = 64'sd42722263;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } target_t;

    typedef struct packed {
        logic [11:0] lift;
        logic [11:0] sh_roll;
        logic [11:0] elbow;
        logic [11:0] wr_pitch;
        logic [11:0] wr_roll;
        logic        reach_fail;
    } servo_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    two_link_arm_inverse_kinematics u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // target_x, target_y, target_z
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // five 12 bit ticks, zero pad
        .m_tuser  (m_tuser),    // out_of_reach
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // predictor copy of the link registers
    longint  link_upper;
    longint  link_lower;

    target_t target_q[$];     // targets waiting to be offered
    servo_t  servo_q[$];      // predicted result beats, oldest first

    int      src_idle_pct;
    int      snk_stall_pct;
    int      hold_cycles;      // long receiver hold-off, counted by the monitor
    int      mismatches;
    int      quiet_cycles;

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;   // arithmetic shift on signed longint floors
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint atan_entry(int i);
        case (i)
            0:  return 843314857;
            1:  return 497837829;
            2:  return 263043837;
            3:  return 133525159;
            4:  return 67021687;
            5:  return 33543516;
            6:  return 16775851;
            7:  return 8388437;
            8:  return 4194283;
            9:  return 2097149;
            10: return 1048576;
            11: return 524288;
            12: return 262144;
            13: return 131072;
            14: return 65536;
            15: return 32768;
            default: return 0;
        endcase
    endfunction

    // vectoring atan2 in q16 radians
    function automatic longint angle_of(longint yv, longint xv);
        longint ang, nx, ny;
        ang = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            ang = (yv >= 0) ? PI_Q30 : -PI_Q30;
            xv = -xv;
            yv = -yv;
        end
        xv = xv * 65536;
        yv = yv * 65536;
        for (int i = 0; i < 16; i++) begin
            if (yv > 0) begin
                nx = xv + floor_shr(yv, i);
                ny = yv - floor_shr(xv, i);
                ang = ang + atan_entry(i);
            end else begin
                nx = xv - floor_shr(yv, i);
                ny = yv + floor_shr(xv, i);
                ang = ang - atan_entry(i);
            end
            xv = nx;
            yv = ny;
        end
        return floor_shr(ang + 8192, 14);
    endfunction

    function automatic longint triangle_angle(longint la, longint lb, longint d2,
                                              longint d_q8, ref bit clamped);
        longint num, den, c;
        num = la * la + d2 - lb * lb;
        den = 2 * la * d_q8;
        if (den == 0) begin
            clamped = 1'b1;
            c = ONE_Q16;
        end else begin
            c = (num * (64'sd1 <<< 24)) / den;   // truncates toward zero
            if (c > ONE_Q16) begin
                c = ONE_Q16;
                clamped = 1'b1;
            end else if (c < -ONE_Q16) begin
                c = -ONE_Q16;
                clamped = 1'b1;
            end
        end
        return angle_of(floor_sqrt(ONE_Q16 * ONE_Q16 - c * c), c);
    endfunction

    function automatic logic [11:0] servo_ticks(longint gain, longint ang, longint ofs);
        longint v;
        v = ofs * (64'sd1 <<< 32) - gain * ang;
        if (v < 0) return 12'd0;
        v = v >>> 32;
        return (v > 4095) ? 12'd4095 : v[11:0];
    endfunction

    function automatic servo_t solve_arm(target_t t);
        longint x, y, z, r2, d2, r_q8, d_q8, roll, b1, b2, alpha;
        bit     clamped;
        servo_t s;
        x = t.x;
        y = t.y;
        z = t.z;
        clamped = 1'b0;
        r2 = y * y + z * z;
        d2 = x * x + r2;
        r_q8 = floor_sqrt(r2 <<< 16);
        d_q8 = floor_sqrt(d2 <<< 16);
        roll = angle_of(y, z);
        b1 = triangle_angle(link_upper, link_lower, d2, d_q8, clamped);
        b2 = triangle_angle(link_lower, link_upper, d2, d_q8, clamped);
        alpha = angle_of(x * 256, r_q8);
        s.lift     = servo_ticks(GAIN_LIFT, alpha - b1, 3000);
        s.sh_roll  = servo_ticks(GAIN_SH_ROLL, roll, 2052);
        s.elbow    = servo_ticks(GAIN_JOINT, b1 + b2, 2048);
        s.wr_pitch = servo_ticks(GAIN_JOINT, HALF_PI_Q16 - alpha - b2, 1948);
        s.wr_roll  = servo_ticks(GAIN_JOINT, -roll, 2048);
        s.reach_fail = clamped;
        return s;
    endfunction

    // ---------------- driver: offers queued targets ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_tready) begin
            // previous beat taken or nothing offered yet
            if (s_tvalid) begin
                servo_q.push_back(solve_arm(target_t'(s_tdata)));
            end
            if (target_q.size() > 0 && $urandom_range(99, 0) >= src_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= target_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor: checks result beats ----------------
    always @(posedge aclk) begin
        servo_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.lift     = m_tdata[11:0];
                got.sh_roll  = m_tdata[23:12];
                got.elbow    = m_tdata[35:24];
                got.wr_pitch = m_tdata[47:36];
                got.wr_roll  = m_tdata[59:48];
                got.reach_fail = m_tuser;
                if (servo_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h user %b", m_tdata, m_tuser);
                end else begin
                    want = servo_q.pop_front();
                    if (got !== want || m_tdata[63:60] !== 4'h0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p, got %p pad %h",
                                     want, got, m_tdata[63:60]);
                    end
                end
            end
            // long hold-off first, then random stalls
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= snk_stall_pct);
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic reg_write(int idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_UPPER) link_upper = val & 32'h3fff;
        else if (idx == REG_LOWER) link_lower = val & 32'h3fff;
    endtask

    // wait until the pipe is empty, then let the tail settle
    task automatic drain();
        while (target_q.size() > 0 || s_tvalid || servo_q.size() > 0) @(posedge aclk);
        repeat (PIPE_LAT + 10) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_coord(int span);
        if (span >= 32768) return 16'($urandom);
        return 16'($signed($urandom_range(2 * span, 0)) - span);
    endfunction

    task automatic queue_target(logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] z);
        target_t t;
        t.x = x;
        t.y = y;
        t.z = z;
        target_q.push_back(t);
    endtask

    task automatic random_phase(int count, int idle, int stall);
        int reach;
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        reach = int'(link_upper + link_lower + 200);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9, 0))
                0, 1:    queue_target(rand_coord(32768), rand_coord(32768),
                                      rand_coord(32768));
                2:       queue_target(rand_coord(8), rand_coord(8), rand_coord(8));
                default: queue_target(rand_coord(reach), rand_coord(reach),
                                      rand_coord(reach));
            endcase
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        link_upper = 2550;
        link_lower = 2250;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_cycles = 0;
        mismatches = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: origin, field extremes, axes, reachable and edge points
        queue_target(0, 0, 0);
        queue_target(16'sh7fff, 16'sh7fff, 16'sh7fff);
        queue_target(-16'sh8000, -16'sh8000, -16'sh8000);
        queue_target(16'sh7fff, 0, 0);
        queue_target(0, -16'sh8000, 0);
        queue_target(0, 0, -16'sh8000);
        queue_target(0, 100, 0);
        queue_target(0, -100, 0);
        queue_target(0, 0, -100);
        queue_target(-300, 0, 0);
        queue_target(3000, 1000, 1500);
        queue_target(4800, 0, 0);
        queue_target(4799, 0, 1);
        queue_target(300, 0, 0);
        queue_target(200, 0, 0);
        queue_target(1, 0, 0);
        queue_target(-1000, -2000, 2000);
        queue_target(1500, -2500, -1200);
        queue_target(-32768, 32767, -1);
        drain();

        // no idling, default links
        random_phase(300, 0, 0);
        drain();

        // extremes of the link registers, including zero link
        reg_write(REG_UPPER, 32'd1);
        reg_write(REG_LOWER, 32'd10000);
        random_phase(250, 54, 0);
        queue_target(9999, 0, 0);
        queue_target(10001, 0, 0);
        drain();

        reg_write(REG_UPPER, 32'd10000);
        reg_write(REG_LOWER, 32'd1);
        random_phase(250, 0, 54);
        drain();

        reg_write(REG_UPPER, 32'd0);
        reg_write(REG_LOWER, 32'hffff_ffff);
        random_phase(50, 36, 36);
        drain();

        // new links with nothing in flight, then the receiver holds off while the sender streams
        reg_write(REG_UPPER, 32'd3000);
        reg_write(REG_LOWER, 32'd3000);
        hold_cycles = 400;
        random_phase(300, 0, 0);
        drain();

        reg_write(REG_UPPER, 32'd2550);
        reg_write(REG_LOWER, 32'd2250);
        random_phase(370, 36, 36);
        drain();

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tlik_pkg.sv
hw/rtl/tlik_cordic_cell.sv
hw/rtl/tlik_sqrt_cell.sv
hw/rtl/tlik_div_cell.sv
hw/rtl/tlik_cordic.sv
hw/rtl/two_link_arm_inverse_kinematics.sv
dv/two_link_arm_inverse_kinematics_tb.sv
